FILE: rtl/core/sfwm_pkg.sv
// Shared types and constants for the shifting FIFO with running mean.
package sfwm_pkg;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 7;
    localparam int MEAN_W  = 40;
    localparam int FRAC_W  = 8;

    localparam logic [1:0] OP_PUSH   = 2'd0;
    localparam logic [1:0] OP_POP    = 2'd1;
    localparam logic [1:0] OP_STATUS = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_DIV
    } t_state;

    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_ctl;

endpackage

FILE: rtl/core/sfwm_cell.sv
// One storage cell of the FIFO chain, loading from its neighbor on a pop or the pushed value when selected.
module sfwm_cell
    import sfwm_pkg::*;
(
    input  logic               i_clk,
    input  t_cell_ctl          i_ctl,
    input  logic               i_sel,
    input  logic [VALUE_W-1:0] i_value,
    input  logic [VALUE_W-1:0] i_next,
    output logic [VALUE_W-1:0] o_data
);

    logic [VALUE_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.pop) begin
            r_data <= i_next;
        end else if (i_ctl.push && i_sel) begin
            r_data <= i_value;
        end
    end

    assign o_data = r_data;

endmodule

FILE: rtl/core/sfwm_div.sv
// Bit-serial restoring divider that forms the signed fixed-point mean.
module sfwm_div
    import sfwm_pkg::*;
#(
    parameter int SUM_W = 39,
    parameter int DEN_W = 7
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [SUM_W-1:0] i_sum,
    input  logic [DEN_W-1:0]        i_den,
    output logic                    o_done,
    output logic signed [MEAN_W-1:0] o_quot
);

    localparam int NUM_W = SUM_W + FRAC_W;
    localparam int CW    = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic             r_neg;
    logic [CW-1:0]    r_cnt;
    logic             r_run;
    logic             r_done;

    logic [SUM_W-1:0]  mag;
    logic [DEN_W:0]    trial;
    logic              fits;
    logic [DEN_W:0]    diff;
    logic [MEAN_W-1:0] q_low;

    assign mag   = i_sum[SUM_W-1] ? (~i_sum + SUM_W'(1)) : i_sum;
    assign trial = {r_rem, r_quo[NUM_W-1]};
    assign fits  = trial >= {1'b0, r_den};
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CW'(NUM_W);
            end else if (r_run) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= {mag, {FRAC_W{1'b0}}};
            r_rem <= '0;
            r_den <= i_den;
            r_neg <= i_sum[SUM_W-1];
        end else if (r_run) begin
            r_rem <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], fits};
        end
    end

    assign q_low  = r_quo[MEAN_W-1:0];
    assign o_quot = r_neg ? -q_low : q_low;
    assign o_done = r_done;

endmodule

FILE: rtl/core/shift_fifo_window_mean.sv
// Top level of the shifting FIFO with a fixed-point running mean.
//
//  channel   signals                                          direction
//  request   start, busy, i_opcode, i_value                   in (busy out)
//  result    o_strobe, o_accepted, o_count, o_is_empty,       out
//            o_is_full, o_mean_q8
//
// A request that leaves the FIFO non-empty passes through the START state and waits in
// the DIV state for the bit-serial mean divider; its result strobe is then registered.
// A request that leaves the FIFO empty goes from the START state to a registered strobe.
// Busy stays high from the request until its result is shown, so requests are
// taken one at a time; the receiver cannot stall and each result lasts one cycle.
// Synchronous reset empties the FIFO and clears the running sum.
module shift_fifo_window_mean
    import sfwm_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               i_opcode,
    input  logic signed [VALUE_W-1:0] i_value,
    output logic                     o_strobe,
    output logic                     o_accepted,
    output logic [COUNT_W-1:0]       o_count,
    output logic                     o_is_empty,
    output logic                     o_is_full,
    output logic signed [MEAN_W-1:0] o_mean_q8
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = VALUE_W + CNT_W;

    t_state r_state, n_state;

    logic [CNT_W-1:0]        r_fill;
    logic signed [SUM_W-1:0] r_sum;
    logic                    r_took;
    logic                    r_strobe;
    logic                    r_accepted;
    logic [COUNT_W-1:0]      r_count;
    logic                    r_is_empty;
    logic                    r_is_full;
    logic [MEAN_W-1:0]       r_mean;

    logic                    take;
    logic                    do_push;
    logic                    do_pop;
    t_cell_ctl               cell_ctl;
    logic [VALUE_W-1:0]      cell_data [DEPTH];
    logic                    div_start;
    logic                    div_done;
    logic signed [MEAN_W-1:0] div_quot;
    logic                    emit;
    logic                    fill_zero;
    logic [CNT_W+COUNT_W-1:0] count_ext;

    assign take      = start && !busy;
    assign do_push   = take && (i_opcode == OP_PUSH) && (r_fill < CNT_W'(DEPTH));
    assign do_pop    = take && (i_opcode == OP_POP) && (r_fill != '0);
    assign cell_ctl  = '{push: do_push, pop: do_pop};
    assign fill_zero = (r_fill == '0);
    assign count_ext = {{COUNT_W{1'b0}}, r_fill};

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [VALUE_W-1:0] next_data;
        if (g == DEPTH - 1) begin : g_last
            assign next_data = '0;
        end else begin : g_mid
            assign next_data = cell_data[g+1];
        end
        sfwm_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (cell_ctl),
            .i_sel   (r_fill == CNT_W'(g)),
            .i_value (i_value),
            .i_next  (next_data),
            .o_data  (cell_data[g])
        );
    end

    sfwm_div #(
        .SUM_W (SUM_W),
        .DEN_W (CNT_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_sum   (r_sum),
        .i_den   (r_fill),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (take) n_state = ST_START;
            ST_START: n_state = fill_zero ? ST_IDLE : ST_DIV;
            ST_DIV:   if (div_done) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        busy      = 1'b1;
        div_start = 1'b0;
        emit      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                busy = 1'b0;
            end
            ST_START: begin
                div_start = !fill_zero;
                emit      = fill_zero;
            end
            ST_DIV: begin
                emit = div_done;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_fill   <= '0;
            r_sum    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= emit;
            if (do_push) begin
                r_fill <= r_fill + CNT_W'(1);
                r_sum  <= r_sum + {{(SUM_W-VALUE_W){i_value[VALUE_W-1]}}, i_value};
            end else if (do_pop) begin
                r_fill <= r_fill - CNT_W'(1);
                r_sum  <= r_sum - {{(SUM_W-VALUE_W){cell_data[0][VALUE_W-1]}}, cell_data[0]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_took <= do_push || do_pop;
        end
        if (emit) begin
            r_accepted <= r_took;
            r_count    <= count_ext[COUNT_W-1:0];
            r_is_empty <= fill_zero;
            r_is_full  <= (r_fill == CNT_W'(DEPTH));
            r_mean     <= fill_zero ? '0 : div_quot;
        end
    end

    assign o_strobe   = r_strobe;
    assign o_accepted = r_accepted;
    assign o_count    = r_count;
    assign o_is_empty = r_is_empty;
    assign o_is_full  = r_is_full;
    assign o_mean_q8  = r_mean;

    a_strobe_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($past(r_state) == ST_START || $past(r_state) == ST_DIV))
        else $error("Result shown without a request in progress.");

    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> !o_strobe)
        else $error("Result shown in the cycle after a request was taken.");

    a_empty_mean_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_is_empty) |-> (o_mean_q8 == '0))
        else $error("Nonzero mean reported for an empty FIFO.");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(DEPTH))
        else $error("Fill count exceeds the FIFO depth.");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for shift_fifo_window_mean with a local FIFO-and-mean predictor.
module tb_top;
    import sfwm_pkg::*;

    localparam int FIFO_DEPTH = 64;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 60;
    localparam longint CYCLE_LIMIT = 600000;

    typedef struct {
        logic               accepted;
        logic [COUNT_W-1:0] count;
        logic               is_empty;
        logic               is_full;
        logic [MEAN_W-1:0]  mean_q8;
    } t_status;

    logic                      i_clk    = 1'b0;
    logic                      i_rst_n  = 1'b0;
    logic                      start    = 1'b0;
    logic [1:0]                i_opcode = OP_STATUS;
    logic signed [VALUE_W-1:0] i_value  = '0;
    logic                      busy;
    logic                      o_strobe;
    logic                      o_accepted;
    logic [COUNT_W-1:0]        o_count;
    logic                      o_is_empty;
    logic                      o_is_full;
    logic signed [MEAN_W-1:0]  o_mean_q8;

    logic signed [VALUE_W-1:0] fifo_slots [FIFO_DEPTH];
    int                        fifo_fill;
    longint                    fifo_sum;
    t_status                   status_queue [$];

    int     mismatches    = 0;
    int     requests_sent = 0;
    int     results_seen  = 0;
    int     refused_count = 0;
    int     full_hits     = 0;
    int     empty_hits    = 0;
    bit     idling_on     = 1'b1;
    longint cycle_count   = 0;

    shift_fifo_window_mean #(
        .DEPTH(FIFO_DEPTH)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_opcode  (i_opcode),
        .i_value   (i_value),
        .o_strobe  (o_strobe),
        .o_accepted(o_accepted),
        .o_count   (o_count),
        .o_is_empty(o_is_empty),
        .o_is_full (o_is_full),
        .o_mean_q8 (o_mean_q8)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles.", cycle_count);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: mismatch on %s, got %0h, expected %0h", $time, field, got, want);
        mismatches++;
    endtask

    function automatic t_status apply_request(input logic [1:0] op,
                                              input logic signed [VALUE_W-1:0] val);
        t_status s;
        longint  mean;
        s.accepted = 1'b0;
        if (op == OP_PUSH && fifo_fill < FIFO_DEPTH) begin
            fifo_slots[fifo_fill] = val;
            fifo_fill++;
            fifo_sum += val;
            s.accepted = 1'b1;
        end else if (op == OP_POP && fifo_fill > 0) begin
            fifo_sum -= fifo_slots[0];
            for (int i = 0; i < FIFO_DEPTH - 1; i++) begin
                fifo_slots[i] = fifo_slots[i + 1];
            end
            fifo_slots[FIFO_DEPTH - 1] = '0;
            fifo_fill--;
            s.accepted = 1'b1;
        end
        mean = 0;
        if (fifo_fill > 0) begin
            mean = (fifo_sum * 256) / longint'(fifo_fill);
        end
        s.count    = fifo_fill[COUNT_W-1:0];
        s.is_empty = (fifo_fill == 0);
        s.is_full  = (fifo_fill == FIFO_DEPTH);
        s.mean_q8  = mean[MEAN_W-1:0];
        return s;
    endfunction

    always @(posedge i_clk) begin : check_results
        t_status want;
        if (i_rst_n && o_strobe) begin
            results_seen++;
            if (status_queue.size() == 0) begin
                report_mismatch("unexpected result", {57'd0, o_count}, 64'd0);
            end else begin
                want = status_queue.pop_front();
                if (o_accepted !== want.accepted) begin
                    report_mismatch("accepted", o_accepted, want.accepted);
                end
                if (o_count !== want.count) begin
                    report_mismatch("count", o_count, want.count);
                end
                if (o_is_empty !== want.is_empty) begin
                    report_mismatch("is_empty", o_is_empty, want.is_empty);
                end
                if (o_is_full !== want.is_full) begin
                    report_mismatch("is_full", o_is_full, want.is_full);
                end
                if (o_mean_q8 !== want.mean_q8) begin
                    report_mismatch("mean_q8", o_mean_q8, want.mean_q8);
                end
            end
        end
    end

    task automatic idle_burst();
        start <= 1'b0;
        if ($urandom_range(0, 1) == 1) begin
            @(posedge i_clk);
            while (busy) @(posedge i_clk);
        end
        repeat ($urandom_range(1, 6)) @(posedge i_clk);
    endtask

    task automatic issue_request(input logic [1:0] op, input logic signed [VALUE_W-1:0] val);
        t_status s;
        start    <= 1'b1;
        i_opcode <= op;
        i_value  <= val;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        s = apply_request(op, val);
        status_queue.push_back(s);
        requests_sent++;
        if ((op == OP_PUSH || op == OP_POP) && !s.accepted) refused_count++;
        if (s.is_full) full_hits++;
        if (s.is_empty) empty_hits++;
        if (idling_on && $urandom_range(0, 3) == 0) idle_burst();
    endtask

    task automatic wait_until_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (status_queue.size() != 0);
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value();
        logic signed [VALUE_W-1:0] v;
        case ($urandom_range(0, 7))
            0:       v = 32'sh7FFF_FFFF;
            1:       v = 32'sh8000_0000;
            2:       v = '0;
            3:       v = '1;
            4:       v = $urandom_range(0, 255);
            5:       v = -$signed({24'd0, 8'($urandom_range(0, 255))});
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic logic [1:0] pick_opcode(input int push_weight);
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return OP_STATUS;
        if (r < 12) return OP_UNUSED;
        if (r < 12 + push_weight) return OP_PUSH;
        return OP_POP;
    endfunction

    task automatic test_directed_corners();
        issue_request(OP_STATUS, '0);
        issue_request(OP_POP, 32'sh1234_5678);
        issue_request(OP_UNUSED, '1);
        issue_request(OP_PUSH, 32'sh7FFF_FFFF);
        issue_request(OP_PUSH, 32'sh8000_0000);
        issue_request(OP_STATUS, '1);
        issue_request(OP_PUSH, -32'sd1);
        issue_request(OP_PUSH, 32'sd1);
        issue_request(OP_PUSH, '0);
        issue_request(OP_UNUSED, 32'sh5555_5555);
        issue_request(OP_POP, '0);
        issue_request(OP_POP, '0);
        issue_request(OP_STATUS, 32'shAAAA_AAAA);
        repeat (3) issue_request(OP_POP, '0);
        issue_request(OP_POP, '0);
        issue_request(OP_PUSH, -32'sd1);
        issue_request(OP_PUSH, '0);
        issue_request(OP_PUSH, '0);
        repeat (3) issue_request(OP_POP, '0);
    endtask

    task automatic test_fill_and_drain(input int fill_kind);
        logic signed [VALUE_W-1:0] v;
        while (fifo_fill < FIFO_DEPTH) begin
            case (fill_kind)
                0:       v = 32'sh7FFF_FFFF;
                1:       v = 32'sh8000_0000;
                default: v = pick_value();
            endcase
            issue_request(OP_PUSH, v);
        end
        issue_request(OP_PUSH, pick_value());
        issue_request(OP_STATUS, pick_value());
        while (fifo_fill > 0) begin
            issue_request(($urandom_range(0, 15) == 0) ? OP_STATUS : OP_POP, pick_value());
        end
        issue_request(OP_POP, pick_value());
    endtask

    task automatic test_random_mix(input int n);
        int push_weight;
        push_weight = 50;
        for (int i = 0; i < n; i++) begin
            if (i % 40 == 0) push_weight = $urandom_range(0, 1) ? 66 : 22;
            issue_request(pick_opcode(push_weight), pick_value());
        end
    endtask

    task automatic test_pause_until_drained();
        repeat (20) issue_request(pick_opcode(50), pick_value());
        wait_until_drained();
        repeat (20) issue_request(pick_opcode(50), pick_value());
    endtask

    initial begin
        for (int i = 0; i < FIFO_DEPTH; i++) fifo_slots[i] = '0;
        fifo_fill = 0;
        fifo_sum  = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_corners();
        test_fill_and_drain(0);
        test_fill_and_drain(1);
        test_fill_and_drain(2);
        test_random_mix(500);
        test_pause_until_drained();
        test_fill_and_drain(2);
        test_random_mix(500);
        idling_on = 1'b0;
        test_random_mix(120);

        wait_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d requests and checked %0d results; %0d pushes or pops were refused.",
                 requests_sent, results_seen, refused_count);
        $display("The FIFO was full after %0d requests and empty after %0d.",
                 full_hits, empty_hits);
        if (mismatches == 0 && status_queue.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
